### src/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
`default_nettype none

package bdlp_pkg;

  // Default button count, the width of the raw level field and the tick width
  localparam int NUM_BUTTONS_DEFAULT = 4;
  localparam int LEVEL_BITS          = 4;
  localparam int TICKS_W             = 16;

  typedef logic [TICKS_W-1:0] ticks_t;

  // Hold time in ticks after reset
  localparam ticks_t LONG_TICKS_RESET = ticks_t'(300);

  // Input command codes
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Input word
  typedef struct packed {
    cmd_t                  cmd;
    logic [LEVEL_BITS-1:0] levels;
    logic [1:0]            button;
  } item_t;

  // Result word
  typedef struct packed {
    logic                  short_press;
    logic                  long_press;
    logic [LEVEL_BITS-1:0] stable_levels;
  } result_t;

endpackage

`default_nettype wire

### src/button_debounce_long_press.sv
// Top level: debouncer with short- and long-press flags, one word per cycle when not stalled.
//
//   channel  direction  handshake               word
//   item     in         item_valid/item_stall   bdlp_pkg::item_t
//   result   out        result_valid/result_stall  bdlp_pkg::result_t
//   cfg      in         cfg_valid/cfg_ready     cfg_data (long_ticks)
//
// One word is accepted per cycle unless item_stall is high; it waits in
// the input register until the update logic can load its result word
// into the result register, which happens once that register is free.
// Reset is synchronous and clears the control and debounce state;
// long_ticks returns to 300 and every countdown is loaded with it.
// A stalled result holds; item_stall rises only when the input register
// is full and cannot move into a full, stalled result register.
`default_nettype none

module button_debounce_long_press #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bdlp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bdlp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  bdlp_pkg::ticks_t  cfg_data
);

  import bdlp_pkg::*;

  localparam int PadW = NUM_BUTTONS + LEVEL_BITS;

  typedef logic [NUM_BUTTONS-1:0] btn_vec_t;

  // Input register
  logic  stage_valid;
  item_t stage_item;

  // Debounce state; the oldest sample of the window is sample_middle
  // before the shift, so only two stored samples are needed
  ticks_t   long_ticks;
  btn_vec_t sample_newest;
  btn_vec_t sample_middle;
  btn_vec_t accepted_level;
  btn_vec_t held_once;
  btn_vec_t short_flag;
  btn_vec_t long_flag;
  ticks_t   hold_countdown [NUM_BUTTONS];

  btn_vec_t sample_newest_next;
  btn_vec_t sample_middle_next;
  btn_vec_t accepted_level_next;
  btn_vec_t held_once_next;
  btn_vec_t short_flag_next;
  btn_vec_t long_flag_next;
  ticks_t   hold_countdown_next [NUM_BUTTONS];
  result_t  result_next;

  logic result_free;
  logic stage_move;
  logic item_take;

  // Handshake: the result register frees when empty or being taken
  assign result_free = !result_valid || !result_stall;
  assign stage_move  = stage_valid && result_free;
  assign item_stall  = stage_valid && !result_free;
  assign item_take   = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;

  // Per-button update for the word in the input register
  always_comb begin
    logic [PadW-1:0] levels_pad;
    logic [PadW-1:0] accepted_pad;
    btn_vec_t        sel;
    ticks_t          dec;
    logic            n_bit;
    logic            m_bit;
    logic            o_bit;

    levels_pad          = {{NUM_BUTTONS{1'b1}}, stage_item.levels};
    sample_newest_next  = sample_newest;
    sample_middle_next  = sample_middle;
    accepted_level_next = accepted_level;
    held_once_next      = held_once;
    short_flag_next     = short_flag;
    long_flag_next      = long_flag;
    hold_countdown_next = hold_countdown;
    dec                 = '0;
    n_bit               = 1'b1;
    m_bit               = 1'b1;
    o_bit               = 1'b1;

    if (stage_item.cmd == CMD_TICK) begin
      sample_newest_next = levels_pad[NUM_BUTTONS-1:0];
      sample_middle_next = sample_newest;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        n_bit = levels_pad[b];
        m_bit = sample_newest[b];
        o_bit = sample_middle[b];
        if (n_bit == m_bit && m_bit == o_bit) begin
          if (o_bit != accepted_level[b]) begin
            accepted_level_next[b] = o_bit;
            if (!o_bit) begin
              // New press: reload countdown, second press in a hold is long
              hold_countdown_next[b] = long_ticks;
              if (!held_once[b]) begin
                held_once_next[b]  = 1'b1;
                short_flag_next[b] = 1'b1;
              end else begin
                long_flag_next[b]  = 1'b1;
                short_flag_next[b] = 1'b0;
              end
            end else begin
              // Stable release: drop long flag and held mark
              long_flag_next[b] = 1'b0;
              held_once_next[b] = 1'b0;
            end
          end else begin
            // Steady level: count down, saturate, force release at zero
            dec = (hold_countdown[b] != '0) ? hold_countdown[b] - ticks_t'(1) : '0;
            hold_countdown_next[b] = dec;
            if (dec == '0) begin
              accepted_level_next[b] = 1'b1;
            end
          end
        end
      end
    end

    // Report the named button; out-of-range index selects nothing
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      sel[b] = (int'(stage_item.button) == b);
    end
    result_next.short_press = |(short_flag_next & sel);
    result_next.long_press  = |(long_flag_next & sel);
    accepted_pad            = {{LEVEL_BITS{1'b0}}, accepted_level_next};
    result_next.stable_levels = accepted_pad[LEVEL_BITS-1:0];

    if (stage_item.cmd == CMD_QUERY) begin
      short_flag_next = short_flag_next & ~sel;
    end
  end

  // Control and debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      result_valid   <= 1'b0;
      long_ticks     <= LONG_TICKS_RESET;
      sample_newest  <= '1;
      sample_middle  <= '1;
      accepted_level <= '1;
      held_once      <= '0;
      short_flag     <= '0;
      long_flag      <= '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        hold_countdown[b] <= LONG_TICKS_RESET;
      end
    end else begin
      if (cfg_valid) begin
        long_ticks <= cfg_data;
      end
      if (item_take) begin
        stage_valid <= 1'b1;
      end else if (stage_move) begin
        stage_valid <= 1'b0;
      end
      if (stage_move) begin
        result_valid   <= 1'b1;
        sample_newest  <= sample_newest_next;
        sample_middle  <= sample_middle_next;
        accepted_level <= accepted_level_next;
        held_once      <= held_once_next;
        short_flag     <= short_flag_next;
        long_flag      <= long_flag_next;
        hold_countdown <= hold_countdown_next;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item_take) begin
      stage_item <= item;
    end
    if (stage_move) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

### src/bdlp_checker.sv
// Port-level checker for the debouncer top level, with its bind.
`default_nettype none

module bdlp_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input bdlp_pkg::result_t result
);

  import bdlp_pkg::*;

  // Hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("stalled result word changed");

  // Reset empties the result register
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A long press always drops the short flag of the same button
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.short_press && result.long_press))
    else $error("short and long press reported together");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
